>>> hdl/i2cpe_pkg.sv
// ----------------------------------------------------------------------------
// i2cpe_pkg
// Shared types, constants and helpers for the parity-bit I2C master engine.
// ----------------------------------------------------------------------------
package i2cpe_pkg;

    // Transmit buffer geometry
    localparam int BUF_DEPTH = 16;
    localparam int BUF_AW    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

    // Field widths
    localparam int POS_W      = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int IN_DATA_W  = 16;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 24;

    // Commands
    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_LOAD   = 2'd1;
    localparam logic [1:0] CMD_QUEUE  = 2'd2;
    localparam logic [1:0] CMD_INJECT = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ADDR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_MODE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_COUNT = 2'd2;

    // Reset value of the byte count register
    localparam logic [POS_W-1:0] BYTE_COUNT_RST = 5'd1;

    // Bits per byte on the wire
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef struct packed {
        logic [6:0]       slave_address;
        logic             read_mode;
        logic [POS_W-1:0] byte_count;
    } cfg_t;

    typedef struct packed {
        logic [1:0] command;
        logic       scl_level;
        logic       sda_level;
        logic       odd_tick;
        logic [3:0] load_index;
        logic [7:0] load_byte;
    } item_t;

    typedef struct packed {
        logic       sda_release;
        logic       scl_release;
        logic       busy_res;
        logic       queue_accepted;
        logic       done_res;
        logic       success;
        logic       arbitration_lost;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic [3:0] rx_index;
        logic       parity_fault;
    } result_t;

    typedef struct packed {
        logic              we;
        logic [BUF_AW-1:0] addr;
        logic [7:0]        data;
    } mem_wr_t;

    // Even parity over one byte
    function automatic logic even_parity(input logic [7:0] v);
        return ^v;
    endfunction

endpackage

>>> hdl/i2cpe_txbuf.sv
// ----------------------------------------------------------------------------
// i2cpe_txbuf
// Transmit byte buffer: one write port, one registered read port that reads
// every cycle, with write-to-read forwarding on an address match.
// ----------------------------------------------------------------------------
module i2cpe_txbuf (
    input  logic                       aclk,
    input  i2cpe_pkg::mem_wr_t         wr,
    input  logic [i2cpe_pkg::BUF_AW-1:0] rd_addr,
    output logic [7:0]                 rd_data
);

    logic [7:0] mem [i2cpe_pkg::BUF_DEPTH];
    logic [7:0] rd_data_reg;

    // Write the loaded byte
    always_ff @(posedge aclk) begin
        if (wr.we) begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Read every cycle; forward a same-cycle write to the same entry
    always_ff @(posedge aclk) begin
        if (wr.we && (wr.addr == rd_addr)) begin
            rd_data_reg <= wr.data;
        end else begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/i2cpe_core.sv
// ----------------------------------------------------------------------------
// i2cpe_core
// Bus sequencer: START, address with parity and ACK, data bytes with parity
// and ACK, STOP. Picks the buffer entry the next beat will need from the next
// state and reads it ahead through the registered read port.
// ----------------------------------------------------------------------------
module i2cpe_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         exec,
    input  i2cpe_pkg::item_t             item,
    input  i2cpe_pkg::cfg_t              cfg,
    output i2cpe_pkg::mem_wr_t           mem_wr,
    output logic [i2cpe_pkg::BUF_AW-1:0] mem_rd_addr,
    input  logic [7:0]                   mem_rd_data,
    output i2cpe_pkg::result_t           result
);

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_START     = 4'd1,
        PH_ADDR_BITS = 4'd2,
        PH_ADDR_PAR  = 4'd3,
        PH_ADDR_ACK  = 4'd4,
        PH_DATA_BITS = 4'd5,
        PH_DATA_PAR  = 4'd6,
        PH_DATA_ACK  = 4'd7,
        PH_STOP      = 4'd8,
        PH_DONE      = 4'd9
    } phase_t;

    typedef enum logic [2:0] {
        MD_IDLE     = 3'd0,
        MD_STARTING = 3'd1,
        MD_TX_ADDR  = 3'd2,
        MD_TX_DATA  = 3'd3,
        MD_RX_DATA  = 3'd4,
        MD_ARB_LOST = 3'd5
    } mode_t;

    localparam int PW = i2cpe_pkg::POS_W;

    phase_t          phase_reg, phase_next;
    mode_t           mode_reg, mode_next;
    logic            pending_reg, pending_next;
    logic [3:0]      bit_cnt_reg, bit_cnt_next;
    logic [7:0]      tx_shift_reg, tx_shift_next;
    logic [7:0]      rx_shift_reg, rx_shift_next;
    logic [PW-1:0]   byte_pos_reg, byte_pos_next;
    logic            parity_flag_reg, parity_flag_next;
    logic            inject_reg, inject_next;
    logic            success_reg, success_next;
    logic            sda_drive_reg, sda_drive_next;
    logic            scl_drive_reg, scl_drive_next;
    logic            rd_in_range_reg, rd_in_range_next;

    logic [7:0]      buf_byte;
    logic [7:0]      addr_byte;
    logic [PW-1:0]   rd_idx;

    // Entries beyond the buffer read as zero
    assign buf_byte  = rd_in_range_reg ? mem_rd_data : 8'h00;
    assign addr_byte = {cfg.slave_address, cfg.read_mode};

    // Next-state logic for one beat
    always_comb begin
        logic          go;
        logic          par;
        logic [PW-1:0] pos_inc;

        go       = 1'b0;
        par      = 1'b0;
        pos_inc  = PW'(byte_pos_reg + 1'b1);

        phase_next       = phase_reg;
        mode_next        = mode_reg;
        pending_next     = pending_reg;
        bit_cnt_next     = bit_cnt_reg;
        tx_shift_next    = tx_shift_reg;
        rx_shift_next    = rx_shift_reg;
        byte_pos_next    = byte_pos_reg;
        parity_flag_next = parity_flag_reg;
        inject_next      = inject_reg;
        success_next     = success_reg;
        sda_drive_next   = sda_drive_reg;
        scl_drive_next   = scl_drive_reg;

        mem_wr.we   = 1'b0;
        mem_wr.addr = i2cpe_pkg::BUF_AW'(item.load_index);
        mem_wr.data = item.load_byte;

        result.queue_accepted   = 1'b0;
        result.done_res         = 1'b0;
        result.success          = 1'b0;
        result.arbitration_lost = 1'b0;
        result.rx_valid         = 1'b0;
        result.rx_byte          = 8'h00;
        result.rx_index         = 4'h0;

        if (exec) begin
            case (item.command)
                i2cpe_pkg::CMD_LOAD: begin
                    mem_wr.we = (int'(item.load_index) < i2cpe_pkg::BUF_DEPTH);
                end
                i2cpe_pkg::CMD_QUEUE: begin
                    if (!pending_reg) begin
                        pending_next          = 1'b1;
                        success_next          = 1'b0;
                        result.queue_accepted = 1'b1;
                    end
                end
                i2cpe_pkg::CMD_INJECT: begin
                    inject_next = 1'b1;
                end
                default: begin
                    // Tick: gate the step, then advance the bus phase
                    go = 1'b1;
                    if (mode_reg == MD_ARB_LOST) begin
                        mode_next = MD_IDLE;
                        go        = 1'b0;
                    end else if (mode_reg == MD_IDLE) begin
                        if (pending_reg && item.scl_level && item.sda_level) begin
                            mode_next  = MD_STARTING;
                            phase_next = PH_START;
                        end else begin
                            go = 1'b0;
                        end
                    end
                    // Slave stretching the clock: hold
                    if (go && !item.scl_level && scl_drive_reg &&
                        phase_next != PH_START && phase_next != PH_STOP) begin
                        go = 1'b0;
                    end
                    if (go && phase_next == PH_DONE) begin
                        pending_next    = 1'b0;
                        mode_next       = MD_IDLE;
                        phase_next      = PH_IDLE;
                        sda_drive_next  = 1'b1;
                        scl_drive_next  = 1'b1;
                        result.done_res = 1'b1;
                        result.success  = success_reg;
                        go              = 1'b0;
                    end
                    if (go && !item.odd_tick) begin
                        go = 1'b0;
                    end
                    if (go) begin
                        case (phase_next)
                            PH_START: begin
                                if (item.sda_level) begin
                                    sda_drive_next = 1'b0;
                                    scl_drive_next = 1'b1;
                                end else begin
                                    scl_drive_next = 1'b0;
                                    phase_next     = PH_ADDR_BITS;
                                    bit_cnt_next   = 4'd0;
                                    tx_shift_next  = addr_byte;
                                    mode_next      = MD_TX_ADDR;
                                end
                            end
                            PH_ADDR_BITS, PH_DATA_BITS: begin
                                if (!item.scl_level) begin
                                    sda_drive_next = (phase_next == PH_ADDR_BITS ||
                                                      mode_reg == MD_TX_DATA) ?
                                                     tx_shift_reg[7] : 1'b1;
                                    scl_drive_next = 1'b1;
                                end else if (phase_next == PH_DATA_BITS &&
                                             mode_reg == MD_RX_DATA) begin
                                    rx_shift_next  = {rx_shift_reg[6:0], item.sda_level};
                                    scl_drive_next = 1'b0;
                                    bit_cnt_next   = bit_cnt_reg + 1'b1;
                                    if (bit_cnt_next == i2cpe_pkg::BITS_PER_BYTE) begin
                                        phase_next = PH_DATA_PAR;
                                    end
                                end else if (tx_shift_reg[7] && !item.sda_level) begin
                                    // Lost arbitration: release the bus
                                    mode_next               = MD_ARB_LOST;
                                    pending_next            = 1'b0;
                                    sda_drive_next          = 1'b1;
                                    scl_drive_next          = 1'b1;
                                    result.done_res         = 1'b1;
                                    result.arbitration_lost = 1'b1;
                                end else begin
                                    scl_drive_next = 1'b0;
                                    tx_shift_next  = {tx_shift_reg[6:0], 1'b0};
                                    bit_cnt_next   = bit_cnt_reg + 1'b1;
                                    if (bit_cnt_next == i2cpe_pkg::BITS_PER_BYTE) begin
                                        phase_next = (phase_next == PH_ADDR_BITS) ?
                                                     PH_ADDR_PAR : PH_DATA_PAR;
                                    end
                                end
                            end
                            PH_ADDR_PAR: begin
                                if (!item.scl_level) begin
                                    par = i2cpe_pkg::even_parity(addr_byte);
                                    if (inject_reg) begin
                                        par         = ~par;
                                        inject_next = 1'b0;
                                    end
                                    sda_drive_next = par;
                                    scl_drive_next = 1'b1;
                                end else begin
                                    scl_drive_next = 1'b0;
                                    phase_next     = PH_ADDR_ACK;
                                end
                            end
                            PH_ADDR_ACK: begin
                                if (!item.scl_level) begin
                                    sda_drive_next = 1'b1;
                                    scl_drive_next = 1'b1;
                                end else begin
                                    scl_drive_next = 1'b0;
                                    if (!item.sda_level) begin
                                        byte_pos_next = '0;
                                        bit_cnt_next  = 4'd0;
                                        phase_next    = PH_DATA_BITS;
                                        if (!cfg.read_mode) begin
                                            mode_next     = MD_TX_DATA;
                                            tx_shift_next = buf_byte;
                                        end else begin
                                            mode_next     = MD_RX_DATA;
                                            rx_shift_next = 8'h00;
                                        end
                                    end else begin
                                        phase_next = PH_STOP;
                                    end
                                end
                            end
                            PH_DATA_PAR: begin
                                if (!item.scl_level) begin
                                    if (mode_reg == MD_TX_DATA) begin
                                        par = i2cpe_pkg::even_parity(buf_byte);
                                        if (inject_reg) begin
                                            par         = ~par;
                                            inject_next = 1'b0;
                                        end
                                        sda_drive_next = par;
                                    end else begin
                                        sda_drive_next = 1'b1;
                                    end
                                    scl_drive_next = 1'b1;
                                end else begin
                                    if (mode_reg == MD_RX_DATA) begin
                                        parity_flag_next =
                                            i2cpe_pkg::even_parity(rx_shift_reg) !=
                                            item.sda_level;
                                    end
                                    scl_drive_next = 1'b0;
                                    phase_next     = PH_DATA_ACK;
                                end
                            end
                            PH_DATA_ACK: begin
                                if (!item.scl_level) begin
                                    if (mode_reg == MD_RX_DATA) begin
                                        sda_drive_next = !(!parity_flag_reg &&
                                            ({1'b0, byte_pos_reg} + 1'b1) <
                                            {1'b0, cfg.byte_count});
                                    end else begin
                                        sda_drive_next = 1'b1;
                                    end
                                    scl_drive_next = 1'b1;
                                end else begin
                                    scl_drive_next = 1'b0;
                                    if (mode_reg == MD_TX_DATA) begin
                                        if (!item.sda_level) begin
                                            byte_pos_next = pos_inc;
                                            if (pos_inc < cfg.byte_count) begin
                                                phase_next    = PH_DATA_BITS;
                                                bit_cnt_next  = 4'd0;
                                                tx_shift_next = buf_byte;
                                            end else begin
                                                success_next = 1'b1;
                                                phase_next   = PH_STOP;
                                            end
                                        end else begin
                                            phase_next = PH_STOP;
                                        end
                                    end else begin
                                        // Present the received byte
                                        result.rx_valid = 1'b1;
                                        result.rx_byte  = rx_shift_reg;
                                        result.rx_index = byte_pos_reg[3:0];
                                        byte_pos_next   = pos_inc;
                                        if (pos_inc < cfg.byte_count && !parity_flag_reg) begin
                                            phase_next    = PH_DATA_BITS;
                                            bit_cnt_next  = 4'd0;
                                            rx_shift_next = 8'h00;
                                        end else begin
                                            success_next = !parity_flag_reg;
                                            phase_next   = PH_STOP;
                                        end
                                    end
                                end
                            end
                            PH_STOP: begin
                                if (!item.scl_level) begin
                                    sda_drive_next = 1'b0;
                                    scl_drive_next = 1'b1;
                                end else begin
                                    sda_drive_next = 1'b1;
                                    phase_next     = PH_DONE;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            endcase
        end

        result.sda_release  = sda_drive_next;
        result.scl_release  = scl_drive_next;
        result.busy_res     = pending_next;
        result.parity_fault = parity_flag_next;
    end

    // Select the buffer entry the next beat may need
    always_comb begin
        case (phase_next)
            PH_ADDR_ACK: rd_idx = '0;
            PH_DATA_ACK: rd_idx = PW'(byte_pos_next + 1'b1);
            default:     rd_idx = byte_pos_next;
        endcase
        rd_in_range_next = (int'(rd_idx) < i2cpe_pkg::BUF_DEPTH);
        mem_rd_addr      = i2cpe_pkg::BUF_AW'(rd_idx);
    end

    // Hold sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            mode_reg        <= MD_IDLE;
            pending_reg     <= 1'b0;
            bit_cnt_reg     <= 4'd0;
            tx_shift_reg    <= 8'h00;
            rx_shift_reg    <= 8'h00;
            byte_pos_reg    <= '0;
            parity_flag_reg <= 1'b0;
            inject_reg      <= 1'b0;
            success_reg     <= 1'b0;
            sda_drive_reg   <= 1'b1;
            scl_drive_reg   <= 1'b1;
            rd_in_range_reg <= 1'b0;
        end else begin
            phase_reg       <= phase_next;
            mode_reg        <= mode_next;
            pending_reg     <= pending_next;
            bit_cnt_reg     <= bit_cnt_next;
            tx_shift_reg    <= tx_shift_next;
            rx_shift_reg    <= rx_shift_next;
            byte_pos_reg    <= byte_pos_next;
            parity_flag_reg <= parity_flag_next;
            inject_reg      <= inject_next;
            success_reg     <= success_next;
            sda_drive_reg   <= sda_drive_next;
            scl_drive_reg   <= scl_drive_next;
            rd_in_range_reg <= rd_in_range_next;
        end
    end

endmodule

>>> hdl/i2c_master_parity_bit_engine.sv
// ----------------------------------------------------------------------------
// i2c_master_parity_bit_engine
// The result beat for an accepted input beat is registered. Throughput: one
// beat per cycle while the result stream is not stalled; the transmit
// buffer entry a beat needs is read ahead from the sequencer's next state,
// so ticks run back to back. Reset (aresetn low, synchronous) idles the
// sequencer, releases both drives, resets the configuration, keeps the buffer.
// ----------------------------------------------------------------------------
module i2c_master_parity_bit_engine (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write port
    input  logic                                cfg_wr_en,
    input  logic [i2cpe_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [i2cpe_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [0] scl_level, [1] sda_level, [2] odd_tick, [6:3] load_index,
    // [14:7] load_byte, [15] zero
    input  logic [i2cpe_pkg::IN_DATA_W-1:0]     s_tdata,
    // [1:0] command
    input  logic [i2cpe_pkg::IN_USER_W-1:0]     s_tuser,
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] sda_release, [1] scl_release, [2] busy_res, [3] queue_accepted,
    // [4] done_res, [5] success, [6] arbitration_lost, [7] rx_valid,
    // [15:8] rx_byte, [19:16] rx_index, [20] parity_fault, [23:21] zero
    output logic [i2cpe_pkg::OUT_DATA_W-1:0]    m_tdata
);

    i2cpe_pkg::cfg_t                 cfg_reg;
    i2cpe_pkg::item_t                item;
    i2cpe_pkg::result_t              result;
    i2cpe_pkg::mem_wr_t              mem_wr;
    logic [i2cpe_pkg::BUF_AW-1:0]    mem_rd_addr;
    logic [7:0]                      mem_rd_data;
    logic                            exec;
    logic                            m_tvalid_reg;
    logic [i2cpe_pkg::OUT_DATA_W-1:0] m_tdata_reg;

    // Unpack the input beat
    assign item.command    = s_tuser[1:0];
    assign item.scl_level  = s_tdata[0];
    assign item.sda_level  = s_tdata[1];
    assign item.odd_tick   = s_tdata[2];
    assign item.load_index = s_tdata[6:3];
    assign item.load_byte  = s_tdata[14:7];

    // Accept while the output register is free or draining
    assign s_tready = !m_tvalid_reg || m_tready;
    assign exec     = s_tvalid && s_tready;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.slave_address <= 7'd0;
            cfg_reg.read_mode     <= 1'b0;
            cfg_reg.byte_count    <= i2cpe_pkg::BYTE_COUNT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                i2cpe_pkg::CFG_SLAVE_ADDR: cfg_reg.slave_address <= cfg_wdata[6:0];
                i2cpe_pkg::CFG_READ_MODE:  cfg_reg.read_mode     <= cfg_wdata[0];
                i2cpe_pkg::CFG_BYTE_COUNT:
                    cfg_reg.byte_count <= cfg_wdata[i2cpe_pkg::POS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    i2cpe_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .exec        (exec),
        .item        (item),
        .cfg         (cfg_reg),
        .mem_wr      (mem_wr),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .result      (result)
    );

    i2cpe_txbuf u_txbuf (
        .aclk    (aclk),
        .wr      (mem_wr),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Hold the result beat until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (exec) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec) begin
            m_tdata_reg <= {3'b000,
                            result.parity_fault,
                            result.rx_index,
                            result.rx_byte,
                            result.rx_valid,
                            result.arbitration_lost,
                            result.success,
                            result.done_res,
                            result.queue_accepted,
                            result.busy_res,
                            result.scl_release,
                            result.sda_release};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
